// ===== src/sfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcr_pkg
// shared constants, types and codes of the frame checksum receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcr_pkg;

  localparam int unsigned BufBytes   = 64;
  localparam int unsigned AddrW      = $clog2(BufBytes);
  localparam int unsigned CntW       = $clog2(BufBytes + 1);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 7;
  localparam int unsigned IdxOutW    = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);
  localparam logic [LenW-1:0] LenReset = LenW'(64);

  typedef enum logic [2:0] {
    PhSync1,
    PhSync2,
    PhKind,
    PhData,
    PhSum
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstSync,
    CfgSecondSync,
    CfgFrameKind,
    CfgFrameLength
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DmpIdle,
    DmpFetch,
    DmpSend
  } dump_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic q_empty;
    logic dump_busy;
  } back_stat_t;

endpackage

// ===== src/sfcr_front.sv =====
// ----------------------------------------------------------------------------
// sfcr_front
// byte parser: hunts for sync and type, stores the frame, checks the sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfcr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [sfcr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sfcr_pkg::ByteW-1:0]           rx_byte_i,
  input  sfcr_pkg::back_stat_t                 stat_i,
  output sfcr_pkg::wr_req_t                    wr_o,
  output logic                                 push_o,
  output logic [sfcr_pkg::CntW-1:0]            push_count_o
);

  logic [sfcr_pkg::ByteW-1:0] first_sync_q, second_sync_q, frame_kind_q;
  logic [sfcr_pkg::LenW-1:0]  frame_length_q;

  sfcr_pkg::phase_e           phase_q, phase_d;
  logic [sfcr_pkg::CntW-1:0]  fill_q, fill_d;
  logic [sfcr_pkg::ByteW-1:0] sum_q, sum_d;
  logic [sfcr_pkg::LenW-1:0]  held_q, held_d;

  logic                       accept;
  logic                       data_full;
  logic                       data_done;
  logic [sfcr_pkg::CntW-1:0]  fill_inc;
  logic [sfcr_pkg::ByteW-1:0] sum_add;

  // hold off requests while a frame waits for or is in its dump
  assign in_stall_o = !stat_i.q_empty || stat_i.dump_busy;
  assign accept     = in_valid_i && !in_stall_o;

  assign fill_inc  = fill_q + sfcr_pkg::CntW'(1);
  assign sum_add   = sum_q + rx_byte_i;
  assign data_full = fill_q >= sfcr_pkg::CntW'(sfcr_pkg::BufBytes - 1);
  assign data_done = ((sfcr_pkg::LenW + 1)'(fill_q) + (sfcr_pkg::LenW + 1)'(2))
                     >= {1'b0, held_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q   <= '0;
      second_sync_q  <= '0;
      frame_kind_q   <= '0;
      frame_length_q <= sfcr_pkg::LenReset;
    end else if (cfg_we_i) begin
      unique case (sfcr_pkg::cfg_idx_e'(cfg_index_i))
        sfcr_pkg::CfgFirstSync:   first_sync_q   <= cfg_data_i;
        sfcr_pkg::CfgSecondSync:  second_sync_q  <= cfg_data_i;
        sfcr_pkg::CfgFrameKind:   frame_kind_q   <= cfg_data_i;
        sfcr_pkg::CfgFrameLength: frame_length_q <= cfg_data_i[sfcr_pkg::LenW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfcr_pkg::PhSync1;
      fill_q  <= '0;
      sum_q   <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      held_q  <= held_d;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        sfcr_pkg::PhSync1: phase_d = (rx_byte_i == first_sync_q) ? sfcr_pkg::PhSync2
                                                                 : sfcr_pkg::PhSync1;
        sfcr_pkg::PhSync2: phase_d = (rx_byte_i == second_sync_q) ? sfcr_pkg::PhKind
                                                                  : sfcr_pkg::PhSync1;
        sfcr_pkg::PhKind:  phase_d = (rx_byte_i == frame_kind_q) ? sfcr_pkg::PhData
                                                                 : sfcr_pkg::PhSync1;
        sfcr_pkg::PhData: begin
          if (data_full) begin
            phase_d = sfcr_pkg::PhSync1;
          end else if (data_done) begin
            phase_d = sfcr_pkg::PhSum;
          end
        end
        sfcr_pkg::PhSum:   phase_d = sfcr_pkg::PhSync1;
        default:           phase_d = sfcr_pkg::PhSync1;
      endcase
    end
  end

  // datapath and store writes
  always_comb begin
    fill_d       = fill_q;
    sum_d        = sum_q;
    held_d       = held_q;
    wr_o         = '0;
    push_o       = 1'b0;
    push_count_o = fill_inc;
    if (accept) begin
      unique case (phase_q)
        sfcr_pkg::PhSync1: begin
          fill_d  = '0;
          sum_d   = rx_byte_i;
          wr_o.en = 1'b1;
          wr_o.addr = '0;
          wr_o.data = rx_byte_i;
        end
        sfcr_pkg::PhSync2: begin
          if (rx_byte_i == second_sync_q) begin
            sum_d     = sum_add;
            wr_o.en   = 1'b1;
            wr_o.addr = sfcr_pkg::AddrW'(1);
            wr_o.data = rx_byte_i;
          end
        end
        sfcr_pkg::PhKind: begin
          if (rx_byte_i == frame_kind_q) begin
            held_d    = frame_length_q;
            fill_d    = sfcr_pkg::CntW'(3);
            sum_d     = sum_add;
            wr_o.en   = 1'b1;
            wr_o.addr = sfcr_pkg::AddrW'(2);
            wr_o.data = rx_byte_i;
          end
        end
        sfcr_pkg::PhData: begin
          if (!data_full) begin
            fill_d    = fill_inc;
            sum_d     = sum_add;
            wr_o.en   = 1'b1;
            wr_o.addr = fill_q[sfcr_pkg::AddrW-1:0];
            wr_o.data = rx_byte_i;
          end
        end
        sfcr_pkg::PhSum: begin
          wr_o.en   = fill_q < sfcr_pkg::CntW'(sfcr_pkg::BufBytes);
          wr_o.addr = fill_q[sfcr_pkg::AddrW-1:0];
          wr_o.data = rx_byte_i;
          if (fill_q < sfcr_pkg::CntW'(sfcr_pkg::BufBytes)) begin
            fill_d = fill_inc;
          end
          push_o = (sum_q == rx_byte_i);
        end
        default: begin
          fill_d = fill_q;
        end
      endcase
    end
  end

  a_push_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (phase_q == sfcr_pkg::PhSum) && accept)
    else $error("frame pushed outside checksum phase");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> push_count_o >= sfcr_pkg::CntW'(5))
    else $error("frame shorter than minimum pushed");

endmodule

// ===== src/sfcr_queue.sv =====
// ----------------------------------------------------------------------------
// sfcr_queue
// short queue of checked frame lengths between parser and dump engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcr_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [sfcr_pkg::CntW-1:0] push_data_i,
  input  logic                      pop_i,
  output logic [sfcr_pkg::CntW-1:0] pop_data_o,
  output logic                      empty_o,
  output logic                      full_o
);

  logic [sfcr_pkg::CntW-1:0]  entry_q [sfcr_pkg::QDepth];
  logic [sfcr_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [sfcr_pkg::QCntW-1:0] count_q;

  function automatic logic [sfcr_pkg::QPtrW-1:0] ptr_next(
    input logic [sfcr_pkg::QPtrW-1:0] p
  );
    return (p == sfcr_pkg::QPtrW'(sfcr_pkg::QDepth - 1)) ? '0 : p + sfcr_pkg::QPtrW'(1);
  endfunction

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == sfcr_pkg::QCntW'(sfcr_pkg::QDepth));
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      unique case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + sfcr_pkg::QCntW'(1);
        2'b01:   count_q <= count_q - sfcr_pkg::QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// ===== src/sfcr_back.sv =====
// ----------------------------------------------------------------------------
// sfcr_back
// frame store and dump engine: plays a checked frame out byte by byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfcr_pkg::wr_req_t             wr_i,
  input  logic                          q_empty_i,
  input  logic [sfcr_pkg::CntW-1:0]     q_count_i,
  output logic                          q_pop_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sfcr_pkg::ByteW-1:0]    frame_byte_o,
  output logic [sfcr_pkg::IdxOutW-1:0]  byte_index_o,
  output logic                          last_byte_o
);

  logic [sfcr_pkg::ByteW-1:0]   mem_q [sfcr_pkg::BufBytes];
  logic [sfcr_pkg::ByteW-1:0]   rd_q;

  sfcr_pkg::dump_e              dump_q, dump_d;
  logic [sfcr_pkg::AddrW-1:0]   idx_q, idx_d;
  logic [sfcr_pkg::CntW-1:0]    len_q, len_d;

  logic                         out_valid_q;
  logic [sfcr_pkg::ByteW-1:0]   out_byte_q;
  logic [sfcr_pkg::IdxOutW-1:0] out_idx_q;
  logic                         out_last_q;

  logic                         out_free;
  logic                         is_last;
  logic                         load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (sfcr_pkg::CntW'(idx_q) + sfcr_pkg::CntW'(1)) == len_q;
  assign busy_o   = (dump_q != sfcr_pkg::DmpIdle);

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign byte_index_o = out_idx_q;
  assign last_byte_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_q <= sfcr_pkg::DmpIdle;
      idx_q  <= '0;
      len_q  <= '0;
    end else begin
      dump_q <= dump_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
    end
  end

  // next state
  always_comb begin
    dump_d = dump_q;
    unique case (dump_q)
      sfcr_pkg::DmpIdle:  if (!q_empty_i) dump_d = sfcr_pkg::DmpFetch;
      sfcr_pkg::DmpFetch: dump_d = sfcr_pkg::DmpSend;
      sfcr_pkg::DmpSend: begin
        if (out_free) begin
          dump_d = is_last ? sfcr_pkg::DmpIdle : sfcr_pkg::DmpFetch;
        end
      end
      default:            dump_d = sfcr_pkg::DmpIdle;
    endcase
  end

  // queue pop, output load and index and length updates
  always_comb begin
    q_pop_o = 1'b0;
    load    = 1'b0;
    idx_d   = idx_q;
    len_d   = len_q;
    unique case (dump_q)
      sfcr_pkg::DmpIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          idx_d   = '0;
          len_d   = q_count_i;
        end
      end
      sfcr_pkg::DmpFetch: begin
        load = 1'b0;
      end
      sfcr_pkg::DmpSend: begin
        if (out_free) begin
          load = 1'b1;
          if (!is_last) begin
            idx_d = idx_q + sfcr_pkg::AddrW'(1);
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= rd_q;
      out_idx_q  <= sfcr_pkg::IdxOutW'(idx_q);
      out_last_q <= is_last;
    end
  end

  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> sfcr_pkg::CntW'(idx_q) < len_q)
    else $error("dump index beyond frame length");

  a_no_write_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !wr_i.en)
    else $error("frame store written during dump");

endmodule

// ===== src/sync_frame_checksum_receiver.sv =====
// ----------------------------------------------------------------------------
// path: checksum byte, queue entry, dump fetch, dump send, output register load
// throughput: parser takes one byte per cycle unless held off; a frame dump gives
// each byte by a store read then an output load, input held off until it ends
// reset: asynchronous, clears the hunt, queue and dump control, config and output valid;
// the frame store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// sync_frame_checksum_receiver
// serial frame receiver with two sync bytes and an additive checksum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_frame_checksum_receiver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfcr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [sfcr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sfcr_pkg::ByteW-1:0]           rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sfcr_pkg::ByteW-1:0]           frame_byte_o,
  output logic [sfcr_pkg::IdxOutW-1:0]         byte_index_o,
  output logic                                 last_byte_o
);

  sfcr_pkg::wr_req_t          wr;
  sfcr_pkg::back_stat_t       stat;
  logic                       push;
  logic [sfcr_pkg::CntW-1:0]  push_count;
  logic                       pop;
  logic [sfcr_pkg::CntW-1:0]  pop_count;
  logic                       q_empty;
  logic                       q_full;
  logic                       dump_busy;

  assign stat.q_empty   = q_empty;
  assign stat.dump_busy = dump_busy;

  sfcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .stat_i       (stat),
    .wr_o         (wr),
    .push_o       (push),
    .push_count_o (push_count)
  );

  sfcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_count),
    .pop_i       (pop),
    .pop_data_o  (pop_count),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  sfcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .q_empty_i    (q_empty),
    .q_count_i    (pop_count),
    .q_pop_o      (pop),
    .busy_o       (dump_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> in_stall_o)
    else $error("input open while queue full");

  a_push_then_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> in_stall_o)
    else $error("input not held off after checked frame");

endmodule
